// ===== hdl/ffba_pkg.sv =====
// Shared types and codes for the first-fit block allocator.
`default_nettype none
package ffba_pkg;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_REALLOC = 2'd2;
    localparam logic [1:0] CMD_NOP     = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOSPACE = 2'd1;
    localparam logic [1:0] ST_BADADDR = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] address;
        logic [15:0] request_size;
    } t_req;

    typedef struct packed {
        logic [15:0] result_address;
        logic [1:0]  status;
        logic [15:0] copy_bytes;
        logic        reused;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_FIT_RD,
        S_FIT_SZ,
        S_FIT_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_CARVE,
        S_TAKE,
        S_PUSH,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// ===== hdl/first_fit_bump_allocator_unit.sv =====
// Top level of the first-fit allocator: block table, free list and sequencer.
// One request at a time; busy stays high from the accepted start until the result
// strobe. Depending on its command, a request searches the block table by address
// entry by entry, examines free-list entries one by one, and moves entries up when
// a reused block is unlinked, so its duration scales with the number of carved and
// freed blocks. The tables sit in single-port synchronous memories, one access per
// cycle; each block-table word carries its free flag, written when the block is
// carved, so the table needs no clearing after reset. The result strobe lasts one
// cycle and cannot be held off.
`default_nettype none
module first_fit_bump_allocator_unit #(
    parameter int MAX_BLOCKS   = 256,
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 8
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire ffba_pkg::t_req  i_req,
    input  wire logic            i_cfg_we,
    input  wire logic [16:0]     i_cfg_wdata,
    output logic                 o_rsp_valid,
    output ffba_pkg::t_rsp       o_rsp
);
    import ffba_pkg::*;

    localparam int AW  = $clog2(MAX_BLOCKS);
    localparam int CW  = AW + 1;
    localparam int BW0 = $clog2(HEAP_BYTES + 1) + 1;
    localparam int BW  = (BW0 > 18) ? BW0 : 18;
    localparam logic [BW-1:0] HEAP_LIM = BW'(HEAP_BYTES);
    localparam logic [BW-1:0] HDR      = BW'(HEADER_BYTES);
    localparam logic [CW-1:0] MAXB     = CW'(MAX_BLOCKS);

    logic [15:0]   m_start [MAX_BLOCKS];
    logic [15:0]   m_size  [MAX_BLOCKS];
    logic          m_free  [MAX_BLOCKS];
    logic [AW-1:0] m_order [MAX_BLOCKS];

    t_state        r_state, n_state;
    t_req          r_req;
    logic [16:0]   r_limit;
    logic [BW-1:0] r_bump, n_bump;
    logic [CW-1:0] r_ccount, n_ccount;
    logic [CW-1:0] r_fcount, n_fcount;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_blk, n_blk;
    logic [AW-1:0] r_cand, n_cand;
    logic          r_realloc, n_realloc;
    logic [15:0]   r_oldsz, n_oldsz;
    t_rsp          r_rsp, n_rsp;
    logic          r_rv, n_rv;

    logic          tbl_we, ord_we;
    logic [AW-1:0] tbl_addr, ord_addr;
    logic [15:0]   tbl_wstart, tbl_wsize, rd_start, rd_size;
    logic          tbl_wfree, rd_free;
    logic [AW-1:0] ord_wdata, rd_order;

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            m_start[tbl_addr] <= tbl_wstart;
            m_size[tbl_addr]  <= tbl_wsize;
            m_free[tbl_addr]  <= tbl_wfree;
        end
        rd_start <= m_start[tbl_addr];
        rd_size  <= m_size[tbl_addr];
        rd_free  <= m_free[tbl_addr];
    end

    always_ff @(posedge i_clk) begin
        if (ord_we) begin
            m_order[ord_addr] <= ord_wdata;
        end
        rd_order <= m_order[ord_addr];
    end

    logic [BW-1:0] lim, payload, endoff;
    logic          is_alloc, is_free_cmd;
    always_comb begin
        lim      = ({{(BW-17){1'b0}}, r_limit} < HEAP_LIM) ?
                   {{(BW-17){1'b0}}, r_limit} : HEAP_LIM;
        payload  = r_bump + HDR;
        endoff   = payload + {{(BW-16){1'b0}}, r_req.request_size};
        is_alloc = (r_req.cmd == CMD_ALLOC) ||
                   (r_req.cmd == CMD_REALLOC && r_req.address == 16'd0);
        is_free_cmd = (r_req.cmd == CMD_FREE) ||
                      (r_req.cmd == CMD_REALLOC && r_req.request_size == 16'd0);
    end

    always_comb begin
        n_state   = r_state;
        n_bump    = r_bump;
        n_ccount  = r_ccount;
        n_fcount  = r_fcount;
        n_idx     = r_idx;
        n_blk     = r_blk;
        n_cand    = r_cand;
        n_realloc = r_realloc;
        n_oldsz   = r_oldsz;
        n_rsp     = r_rsp;
        n_rv      = 1'b0;
        tbl_we    = 1'b0;
        tbl_addr  = r_idx[AW-1:0];
        tbl_wstart = payload[15:0];
        tbl_wsize  = r_req.request_size;
        tbl_wfree  = 1'b0;
        ord_we    = 1'b0;
        ord_addr  = r_idx[AW-1:0];
        ord_wdata = r_blk;
        busy      = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_rsp     = '0;
                    n_realloc = 1'b0;
                    n_idx     = '0;
                    n_state   = S_FIND_RD;
                end
            end
            S_FIND_RD: begin
                if (is_alloc) begin
                    n_idx   = r_fcount;
                    n_state = S_FIT_RD;
                end else if (r_req.cmd != CMD_FREE && r_req.cmd != CMD_REALLOC) begin
                    n_state = S_DONE;
                end else if (is_free_cmd && r_req.address == 16'd0) begin
                    n_state = S_DONE;
                end else if (r_idx >= r_ccount) begin
                    n_rsp.status = ST_BADADDR;
                    n_state = S_DONE;
                end else begin
                    tbl_addr = r_idx[AW-1:0];
                    n_state  = S_FIND_CHK;
                end
            end
            S_FIND_CHK: begin
                if (rd_start == r_req.address) begin
                    n_blk   = r_idx[AW-1:0];
                    n_oldsz = rd_size;
                    if (rd_free) begin
                        n_rsp.status = ST_BADADDR;
                        n_state = S_DONE;
                    end else if (is_free_cmd) begin
                        n_state = S_PUSH;
                    end else if (r_req.request_size <= rd_size) begin
                        n_rsp.result_address = r_req.address;
                        n_state = S_DONE;
                    end else begin
                        n_realloc = 1'b1;
                        n_idx     = r_fcount;
                        n_state   = S_FIT_RD;
                    end
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_FIND_RD;
                end
            end
            S_FIT_RD: begin
                if (r_idx == '0) begin
                    n_state = S_CARVE;
                end else begin
                    ord_addr = AW'(r_idx - 1'b1);
                    n_state  = S_FIT_SZ;
                end
            end
            S_FIT_SZ: begin
                n_cand   = rd_order;
                tbl_addr = rd_order;
                n_state  = S_FIT_CHK;
            end
            S_FIT_CHK: begin
                if (r_req.request_size <= rd_size) begin
                    n_rsp.result_address = rd_start;
                    n_rsp.reused = 1'b1;
                    tbl_we     = 1'b1;
                    tbl_addr   = r_cand;
                    tbl_wstart = rd_start;
                    tbl_wsize  = rd_size;
                    tbl_wfree  = 1'b0;
                    n_state    = S_SHIFT_RD;
                end else begin
                    n_idx   = r_idx - 1'b1;
                    n_state = S_FIT_RD;
                end
            end
            S_SHIFT_RD: begin
                if (r_idx >= r_fcount) begin
                    n_fcount = r_fcount - 1'b1;
                    n_state  = r_realloc ? S_TAKE : S_DONE;
                end else begin
                    ord_addr = r_idx[AW-1:0];
                    n_state  = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR: begin
                ord_we    = 1'b1;
                ord_addr  = AW'(r_idx - 1'b1);
                ord_wdata = rd_order;
                n_idx     = r_idx + 1'b1;
                n_state   = S_SHIFT_RD;
            end
            S_CARVE: begin
                if (r_ccount >= MAXB || endoff > lim || payload > BW'(16'hFFFF)) begin
                    n_rsp.status = ST_NOSPACE;
                    n_state = S_DONE;
                end else begin
                    tbl_we   = 1'b1;
                    tbl_addr = r_ccount[AW-1:0];
                    n_ccount = r_ccount + 1'b1;
                    n_bump   = endoff;
                    n_rsp.result_address = payload[15:0];
                    n_state  = r_realloc ? S_TAKE : S_DONE;
                end
            end
            S_TAKE: begin
                n_rsp.copy_bytes = r_oldsz;
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (r_fcount < MAXB) begin
                    ord_we     = 1'b1;
                    ord_addr   = r_fcount[AW-1:0];
                    ord_wdata  = r_blk;
                    tbl_we     = 1'b1;
                    tbl_addr   = r_blk;
                    tbl_wstart = r_req.address;
                    tbl_wsize  = r_oldsz;
                    tbl_wfree  = 1'b1;
                    n_fcount   = r_fcount + 1'b1;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_rv    = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_limit   <= 17'd65536;
            r_bump    <= '0;
            r_ccount  <= '0;
            r_fcount  <= '0;
            r_rv      <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_bump   <= n_bump;
            r_ccount <= n_ccount;
            r_fcount <= n_fcount;
            r_rv     <= n_rv;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && start) begin
            r_req <= i_req;
        end
        r_idx     <= n_idx;
        r_blk     <= n_blk;
        r_cand    <= n_cand;
        r_realloc <= n_realloc;
        r_oldsz   <= n_oldsz;
        r_rsp     <= n_rsp;
    end

    assign o_rsp_valid = r_rv;
    assign o_rsp       = r_rsp;

endmodule
`default_nettype wire
